// ----- hw/rtl/mrpu_pkg.sv -----
package mrpu_pkg;

	// Packing format codes held in the format_mode register.
	localparam logic [1:0] MODE_RAW10 = 2'd0;
	localparam logic [1:0] MODE_RAW12 = 2'd1;
	localparam logic [1:0] MODE_RAW14 = 2'd2;

	localparam int BYTE_W     = 8;
	localparam int PIXEL_W    = 14;
	localparam int MAX_PIXELS = 4;
	localparam int GROUP_BUF  = 6;
	localparam int POS_W      = 3;
	localparam int IDX_W      = 2;
	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 16;

	// Depth of the queue of finished groups between front and back.
	localparam int QUEUE_DEPTH_DEFAULT = 2;

	// Last byte index of a group (group length minus one) per format.
	localparam logic [POS_W-1:0] LAST_POS_RAW10 = 3'd4;
	localparam logic [POS_W-1:0] LAST_POS_RAW12 = 3'd2;
	localparam logic [POS_W-1:0] LAST_POS_RAW14 = 3'd6;

	// One finished group: its pixels in order and the index of the last one.
	typedef struct packed {
		logic [MAX_PIXELS-1:0][PIXEL_W-1:0] pixels;
		logic [IDX_W-1:0]                   last_idx;
	} group_t;

endpackage

// ----- hw/rtl/mipi_raw_pixel_unpacker_unit.sv -----
// Unpacker for MIPI CSI-2 RAW10, RAW12 and RAW14 byte streams.
// The slave stream carries one packed byte per transaction in s_tdata. The
// master stream carries one pixel per transaction, right aligned in m_tdata,
// with m_tlast high on the last pixel of each packing group (4 pixels for
// RAW10 and RAW14, 2 for RAW12). format_mode is written through
// format_mode_wr while the block is idle; code 3 discards incoming bytes.
// Throughput: one byte per cycle in, one pixel per cycle out. The front
// buffers the leading bytes of a group and, on its last byte, builds all
// pixels at once into a small group queue (QUEUE_DEPTH entries); the back
// drains the head entry one pixel per cycle through an output register.
// The last byte of a group writes a queue entry, and the group's pixels
// then reach m_tdata through the output register.
// When the receiver stalls, pixels wait in the output register and the
// queue; s_tready drops only once the queue is full.
// Reset clears the format to RAW10, the byte buffer to zero, the group
// position and the queue; no clearing pass is needed.
module mipi_raw_pixel_unpacker_unit #(
	parameter int QUEUE_DEPTH = mrpu_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              format_mode_wr,
	input  logic [1:0]                        format_mode,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mrpu_pkg::TDATA_IN_W-1:0]   s_tdata,  // [7:0] data_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mrpu_pkg::TDATA_OUT_W-1:0]  m_tdata,  // [13:0] pixel, [15:14] zero
	output logic                              m_tlast
);
	import mrpu_pkg::*;

	group_t push_group;
	group_t head_group;
	logic   push;
	logic   pop;
	logic   queue_empty;
	logic   queue_full;

	// Byte intake and group assembly.
	mrpu_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.format_mode_wr (format_mode_wr),
		.format_mode    (format_mode),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.queue_full     (queue_full),
		.push           (push),
		.push_group     (push_group)
	);

	// Queue of finished groups.
	mrpu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.head_group (head_group),
		.empty      (queue_empty),
		.full       (queue_full)
	);

	// Pixel serialiser and output register.
	mrpu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_group  (head_group),
		.queue_empty (queue_empty),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule

// ----- hw/rtl/mrpu_front.sv -----
module mrpu_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           format_mode_wr,
	input  logic [1:0]                     format_mode,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mrpu_pkg::BYTE_W-1:0]    s_tdata,
	input  logic                           queue_full,
	output logic                           push,
	output mrpu_pkg::group_t               push_group
);
	import mrpu_pkg::*;

	logic [1:0]        mode_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] group_bytes_q [GROUP_BUF];
	logic [POS_W-1:0]  last_pos;
	logic              mode_ok;
	logic              accept;
	logic              group_done;
	logic [23:0]       low_word;

	// Configuration register; the user must write it only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RAW10;
		end else if (format_mode_wr) begin
			mode_q <= format_mode;
		end
	end

	// Decode the group length of the current format.
	always_comb begin
		mode_ok  = 1'b1;
		last_pos = LAST_POS_RAW10;
		unique case (mode_q)
			MODE_RAW10: last_pos = LAST_POS_RAW10;
			MODE_RAW12: last_pos = LAST_POS_RAW12;
			MODE_RAW14: last_pos = LAST_POS_RAW14;
			default: begin
				mode_ok  = 1'b0;
				last_pos = LAST_POS_RAW10;
			end
		endcase
	end

	assign s_tready   = !queue_full;
	assign accept     = s_tvalid && s_tready;
	assign group_done = (pos_q >= last_pos);
	assign push       = accept && mode_ok && group_done;

	// Buffer the leading bytes of a group and track the position within it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < GROUP_BUF; i++) begin
				group_bytes_q[i] <= '0;
			end
		end else if (accept && mode_ok) begin
			if (group_done) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				for (int i = 0; i < GROUP_BUF; i++) begin
					if (pos_q == POS_W'(i)) begin
						group_bytes_q[i] <= s_tdata;
					end
				end
			end
		end
	end

	// Assemble the pixels of a completed group from the buffer and the last byte.
	assign low_word = {s_tdata, group_bytes_q[5], group_bytes_q[4]};

	always_comb begin
		push_group = '0;
		case (mode_q)
			MODE_RAW12: begin
				push_group.pixels[0] = {2'b00, group_bytes_q[0], s_tdata[3:0]};
				push_group.pixels[1] = {2'b00, group_bytes_q[1], s_tdata[7:4]};
				push_group.last_idx  = IDX_W'(1);
			end
			MODE_RAW14: begin
				for (int i = 0; i < MAX_PIXELS; i++) begin
					push_group.pixels[i] = {group_bytes_q[i], low_word[6*i +: 6]};
				end
				push_group.last_idx = IDX_W'(3);
			end
			default: begin
				for (int i = 0; i < MAX_PIXELS; i++) begin
					push_group.pixels[i] = {4'b0000, group_bytes_q[i], s_tdata[2*i +: 2]};
				end
				push_group.last_idx = IDX_W'(3);
			end
		endcase
	end

endmodule

// ----- hw/rtl/mrpu_queue.sv -----
module mrpu_queue #(
	parameter int DEPTH = mrpu_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mrpu_pkg::group_t  push_group,
	input  logic              pop,
	output mrpu_pkg::group_t  head_group,
	output logic              empty,
	output logic              full
);
	import mrpu_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	group_t             entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign empty      = (count_q == '0);
	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_group = entries_q[rd_ptr_q];

	// Entry storage; written only on a push.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_group;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/mrpu_back.sv -----
module mrpu_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mrpu_pkg::group_t                  head_group,
	input  logic                              queue_empty,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mrpu_pkg::TDATA_OUT_W-1:0]  m_tdata,
	output logic                              m_tlast
);
	import mrpu_pkg::*;

	logic [IDX_W-1:0]   pix_idx_q;
	logic [PIXEL_W-1:0] pixel_q;
	logic               last_q;
	logic               valid_q;
	logic               load;
	logic               is_last;

	// Move one pixel into the output register whenever it is free.
	assign load    = !queue_empty && (!valid_q || m_tready);
	assign is_last = (pix_idx_q == head_group.last_idx);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			pix_idx_q <= '0;
		end else begin
			if (load) begin
				valid_q   <= 1'b1;
				pix_idx_q <= is_last ? '0 : pix_idx_q + 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			pixel_q <= head_group.pixels[pix_idx_q];
			last_q  <= is_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = TDATA_OUT_W'(pixel_q);
	assign m_tlast  = last_q;

endmodule

// ----- verif/tb.sv -----
module tb;
	import mrpu_pkg::*;

	// Code 3 is not a packing format: the block discards bytes while it is set.
	localparam logic [1:0] MODE_DISCARD = 2'd3;

	// Cycles to let pass once the last expected pixel has arrived.
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_BYTES  = 350;
	localparam int NUM_DIRECTED  = 23;

	// One expected pixel transaction on the master side.
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               last;
	} pixel_exp_t;

	// One row of the directed table: an optional format write, then one byte.
	// Where typed is set, the row's group yields exp_n pixels all equal to exp_px.
	typedef struct packed {
		logic               set_mode;
		logic [1:0]         mode;
		logic [7:0]         data;
		logic               typed;
		logic [2:0]         exp_n;
		logic [PIXEL_W-1:0] exp_px;
	} dir_step_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   format_mode_wr = 1'b0;
	logic [1:0]             format_mode = MODE_RAW10;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   m_tlast;

	// Predictor state: buffered bytes of the current group and the format.
	logic [7:0]       grp_buf [GROUP_BUF];
	logic [POS_W-1:0] grp_pos;
	logic [1:0]       cur_mode;

	pixel_exp_t pixel_expect_q [$];
	dir_step_t  directed_steps [NUM_DIRECTED];
	int         fail_count = 0;
	int         cycle_count = 0;
	int         send_quiet = 0;
	int         recv_quiet = 0;

	mipi_raw_pixel_unpacker_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.format_mode_wr (format_mode_wr),
		.format_mode    (format_mode),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Wait before a transaction: mostly random, with occasional quiet stretches.
	function automatic int draw_wait(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			quiet_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Takes one accepted byte and returns the pixels that complete a group.
	function automatic void unpack_byte(input logic [7:0] b,
			output logic [MAX_PIXELS-1:0][PIXEL_W-1:0] px, output int n);
		int          len;
		logic [23:0] lows;
		px = '0;
		n = 0;
		case (cur_mode)
			MODE_RAW10: len = 5;
			MODE_RAW12: len = 3;
			MODE_RAW14: len = 7;
			default: return;
		endcase
		// Leading bytes of the group are only buffered.
		if (int'(grp_pos) + 1 < len) begin
			grp_buf[grp_pos] = b;
			grp_pos = grp_pos + 1'b1;
			return;
		end
		grp_pos = '0;
		case (cur_mode)
			MODE_RAW10: begin
				for (int k = 0; k < 4; k++)
					px[k] = PIXEL_W'({grp_buf[k], b[2*k +: 2]});
				n = 4;
			end
			MODE_RAW12: begin
				for (int k = 0; k < 2; k++)
					px[k] = PIXEL_W'({grp_buf[k], b[4*k +: 4]});
				n = 2;
			end
			default: begin
				// Low six bits of each pixel, LSB first across the last three bytes.
				lows = {b, grp_buf[5], grp_buf[4]};
				for (int k = 0; k < 4; k++)
					px[k] = {grp_buf[k], lows[6*k +: 6]};
				n = 4;
			end
		endcase
	endfunction

	task automatic report_fail(input string what, input logic [15:0] exp_px, input logic exp_last,
			input logic [15:0] got_px, input logic got_last);
		fail_count++;
		if (fail_count <= 10)
			$display("%s: expected pixel %h last %b, got pixel %h last %b",
				what, exp_px, exp_last, got_px, got_last);
	endtask

	// Offers one byte, holds it until the transaction completes, then predicts.
	task automatic send_byte(input logic [7:0] d, input logic typed, input int exp_n,
			input logic [PIXEL_W-1:0] exp_px);
		int                                  gap;
		int                                  n;
		logic [MAX_PIXELS-1:0][PIXEL_W-1:0]  px;
		gap = draw_wait(send_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		unpack_byte(d, px, n);
		if (typed) begin
			n  = exp_n;
			px = {MAX_PIXELS{exp_px}};
		end
		for (int k = 0; k < n; k++)
			pixel_expect_q.push_back('{pixel: px[k], last: (k == n - 1)});
	endtask

	// Stops sending and waits until every expected pixel has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pixel_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Format writes happen only with the block idle.
	task automatic set_format(input logic [1:0] m);
		wait_drained();
		format_mode_wr <= 1'b1;
		format_mode    <= m;
		@(posedge clk);
		format_mode_wr <= 1'b0;
		cur_mode = m;
	endtask

	// Receiver: random back-pressure, one pixel transaction checked at a time.
	initial begin
		pixel_exp_t exp_item;
		int         stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(recv_quiet);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			if (pixel_expect_q.size() == 0) begin
				report_fail("Unexpected pixel", 'x, 1'bx, m_tdata, m_tlast);
			end else begin
				exp_item = pixel_expect_q.pop_front();
				if (m_tdata !== {2'b00, exp_item.pixel} || m_tlast !== exp_item.last)
					report_fail("Pixel mismatch", {2'b00, exp_item.pixel}, exp_item.last,
						m_tdata, m_tlast);
			end
		end
	end

	// Stimulus: directed table, then random phases of whole and partial groups.
	initial begin
		int         sent;
		int         len;
		int         nbytes;
		logic [1:0] m;

		directed_steps = '{
			// RAW10 after reset, all bytes at maximum.
			'{1'b0, MODE_RAW10, 8'hFF, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW10, 8'hFF, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW10, 8'hFF, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW10, 8'hFF, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW10, 8'hFF, 1'b1, 3'd4, 14'h03FF},
			// RAW12, all bytes zero.
			'{1'b1, MODE_RAW12, 8'h00, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW12, 8'h00, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW12, 8'h00, 1'b1, 3'd2, 14'h0000},
			// RAW14, all bytes at maximum.
			'{1'b1, MODE_RAW14, 8'hFF, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW14, 8'hFF, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW14, 8'hFF, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW14, 8'hFF, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW14, 8'hFF, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW14, 8'hFF, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW14, 8'hFF, 1'b1, 3'd4, 14'h3FFF},
			// Reserved format: bytes are dropped.
			'{1'b1, MODE_DISCARD, 8'hA5, 1'b1, 3'd0, 14'h0000},
			'{1'b0, MODE_DISCARD, 8'h5A, 1'b1, 3'd0, 14'h0000},
			// Two RAW10 bytes, then RAW12 mid-group: the next byte closes the group.
			'{1'b1, MODE_RAW10, 8'h12, 1'b0, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW10, 8'h34, 1'b0, 3'd0, 14'h0000},
			'{1'b1, MODE_RAW12, 8'hC3, 1'b0, 3'd0, 14'h0000},
			// RAW14 group left incomplete; the random part changes format on top.
			'{1'b1, MODE_RAW14, 8'h81, 1'b0, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW14, 8'h7E, 1'b0, 3'd0, 14'h0000},
			'{1'b0, MODE_RAW14, 8'h99, 1'b0, 3'd0, 14'h0000}
		};

		for (int i = 0; i < GROUP_BUF; i++)
			grp_buf[i] = 8'h00;
		grp_pos  = '0;
		cur_mode = MODE_RAW10;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (directed_steps[i].set_mode)
				set_format(directed_steps[i].mode);
			send_byte(directed_steps[i].data, directed_steps[i].typed,
				int'(directed_steps[i].exp_n), directed_steps[i].exp_px);
		end

		// Random phases; a trailing partial group carries into the next format.
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) == 0)
				m = MODE_DISCARD;
			else
				m = 2'($urandom_range(0, 2));
			set_format(m);
			case (m)
				MODE_RAW10: len = 5;
				MODE_RAW12: len = 3;
				MODE_RAW14: len = 7;
				default:    len = 0;
			endcase
			if (len == 0) begin
				repeat ($urandom_range(1, 6)) send_byte(rand_byte(), 1'b0, 0, '0);
			end else begin
				nbytes = len * $urandom_range(1, 8);
				if ($urandom_range(0, 2) == 0)
					nbytes += $urandom_range(1, len - 1);
				repeat (nbytes) begin
					send_byte(rand_byte(), 1'b0, 0, '0);
					sent++;
				end
			end
		end

		wait_drained();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
